[rtl/tlbt_pkg.sv]
package tlbt_pkg;

  localparam int FIELD_W          = 16;
  localparam int CMD_W            = 2;
  localparam int STATUS_W         = 3;
  localparam int COUNT_W          = 7;

  localparam int ENTRIES_DEFAULT  = 64;
  localparam int KEY_BITS_DEFAULT = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAG_BY_TRIPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRIPLE_BY_TAG = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TRIPLE_EXISTS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LABEL_EXISTS  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL          = 3'd4;

  typedef struct packed {
    logic triple_hit;
    logic tag_hit;
    logic full;
  } match_t;

endpackage

[rtl/tlbt_cam.sv]
module tlbt_cam #(
  parameter int ENTRIES = tlbt_pkg::ENTRIES_DEFAULT,
  parameter int KW      = tlbt_pkg::KEY_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KW-1:0]     key_first,
  input  logic [KW-1:0]     key_second,
  input  logic [KW-1:0]     key_third,
  input  logic [KW-1:0]     key_tag,
  input  logic              wr_en,
  output tlbt_pkg::match_t  match,
  output logic [KW-1:0]     rd_tag,
  output logic [KW-1:0]     rd_first,
  output logic [KW-1:0]     rd_second,
  output logic [KW-1:0]     rd_third
);

  logic [ENTRIES-1:0] slot_valid;
  logic [KW-1:0]      slot_first  [ENTRIES];
  logic [KW-1:0]      slot_second [ENTRIES];
  logic [KW-1:0]      slot_third  [ENTRIES];
  logic [KW-1:0]      slot_tag    [ENTRIES];

  logic [ENTRIES-1:0] triple_hits;
  logic [ENTRIES-1:0] tag_hits;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] lowest_free;

  always_comb begin
    for (int s = 0; s < ENTRIES; s++) begin
      triple_hits[s] = slot_valid[s] && slot_first[s] == key_first &&
                       slot_second[s] == key_second && slot_third[s] == key_third;
      tag_hits[s]    = slot_valid[s] && slot_tag[s] == key_tag;
    end
  end

  assign free        = ~slot_valid;
  assign lowest_free = free & (~free + {{(ENTRIES-1){1'b0}}, 1'b1});

  assign match.triple_hit = |triple_hits;
  assign match.tag_hit    = |tag_hits;
  assign match.full       = ~|free;

  always_comb begin
    rd_tag    = '0;
    rd_first  = '0;
    rd_second = '0;
    rd_third  = '0;
    for (int s = 0; s < ENTRIES; s++) begin
      rd_tag    = rd_tag    | (slot_tag[s]    & {KW{triple_hits[s]}});
      rd_first  = rd_first  | (slot_first[s]  & {KW{tag_hits[s]}});
      rd_second = rd_second | (slot_second[s] & {KW{tag_hits[s]}});
      rd_third  = rd_third  | (slot_third[s]  & {KW{tag_hits[s]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid <= slot_valid | lowest_free;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ENTRIES; s++) begin
      if (wr_en && lowest_free[s]) begin
        slot_first[s]  <= key_first;
        slot_second[s] <= key_second;
        slot_third[s]  <= key_third;
        slot_tag[s]    <= key_tag;
      end
    end
  end

  a_triple_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(triple_hits))
    else $error("triple stored in more than one slot");

  a_tag_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tag_hits))
    else $error("label stored in more than one slot");

  a_free_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(lowest_free))
    else $error("more than one free slot picked for insert");

endmodule

[rtl/triple_label_bidirectional_table.sv]
// Channel   Ports                                              Handshake
// command   cmd first second third tag                         start & !busy
// result    status found_tag found_first found_second          done, one cycle
//           found_third entry_count
//
// One command per cycle while busy is low; done follows the accepted beat via
// the input register, then the parallel slot compare into the result register.
// The next command sees the table as left by the one before it.
// Synchronous reset clears all slot valid bits at once; busy holds high during
// reset and in the cycle after it.
// The receiver cannot stall: each result is shown for exactly one cycle.
module triple_label_bidirectional_table #(
  parameter int ENTRIES  = tlbt_pkg::ENTRIES_DEFAULT,
  parameter int KEY_BITS = tlbt_pkg::KEY_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tlbt_pkg::CMD_W-1:0]    cmd,
  input  logic [tlbt_pkg::FIELD_W-1:0]  first,
  input  logic [tlbt_pkg::FIELD_W-1:0]  second,
  input  logic [tlbt_pkg::FIELD_W-1:0]  third,
  input  logic [tlbt_pkg::FIELD_W-1:0]  tag,
  output logic                          done,
  output logic [tlbt_pkg::STATUS_W-1:0] status,
  output logic [tlbt_pkg::FIELD_W-1:0]  found_tag,
  output logic [tlbt_pkg::FIELD_W-1:0]  found_first,
  output logic [tlbt_pkg::FIELD_W-1:0]  found_second,
  output logic [tlbt_pkg::FIELD_W-1:0]  found_third,
  output logic [tlbt_pkg::COUNT_W-1:0]  entry_count
);

  localparam int KW    = KEY_BITS < tlbt_pkg::FIELD_W ? KEY_BITS : tlbt_pkg::FIELD_W;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic                         busy_q;
  logic                         in_valid;
  logic [tlbt_pkg::CMD_W-1:0]   in_cmd;
  logic [KW-1:0]                in_first;
  logic [KW-1:0]                in_second;
  logic [KW-1:0]                in_third;
  logic [KW-1:0]                in_tag;

  tlbt_pkg::match_t             match;
  logic [KW-1:0]                rd_tag;
  logic [KW-1:0]                rd_first;
  logic [KW-1:0]                rd_second;
  logic [KW-1:0]                rd_third;

  logic                         wr_en;
  logic [tlbt_pkg::STATUS_W-1:0] status_next;
  logic [tlbt_pkg::FIELD_W-1:0] found_tag_next;
  logic [tlbt_pkg::FIELD_W-1:0] found_first_next;
  logic [tlbt_pkg::FIELD_W-1:0] found_second_next;
  logic [tlbt_pkg::FIELD_W-1:0] found_third_next;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;

  assign busy = busy_q | rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd    <= cmd;
      in_first  <= first[KW-1:0];
      in_second <= second[KW-1:0];
      in_third  <= third[KW-1:0];
      in_tag    <= tag[KW-1:0];
    end
  end

  tlbt_cam #(
    .ENTRIES (ENTRIES),
    .KW      (KW)
  ) u_cam (
    .clk        (clk),
    .rst        (rst),
    .key_first  (in_first),
    .key_second (in_second),
    .key_third  (in_third),
    .key_tag    (in_tag),
    .wr_en      (wr_en),
    .match      (match),
    .rd_tag     (rd_tag),
    .rd_first   (rd_first),
    .rd_second  (rd_second),
    .rd_third   (rd_third)
  );

  always_comb begin
    wr_en             = 1'b0;
    status_next       = tlbt_pkg::ST_NOT_FOUND;
    found_tag_next    = '0;
    found_first_next  = '0;
    found_second_next = '0;
    found_third_next  = '0;
    case (in_cmd)
      tlbt_pkg::CMD_INSERT: begin
        if (match.triple_hit) begin
          status_next = tlbt_pkg::ST_TRIPLE_EXISTS;
        end else if (match.tag_hit) begin
          status_next = tlbt_pkg::ST_LABEL_EXISTS;
        end else if (match.full) begin
          status_next = tlbt_pkg::ST_FULL;
        end else begin
          status_next = tlbt_pkg::ST_OK;
          wr_en       = in_valid;
        end
      end
      tlbt_pkg::CMD_TAG_BY_TRIPLE: begin
        if (match.triple_hit) begin
          status_next    = tlbt_pkg::ST_OK;
          found_tag_next = tlbt_pkg::FIELD_W'(rd_tag);
        end
      end
      tlbt_pkg::CMD_TRIPLE_BY_TAG: begin
        if (match.tag_hit) begin
          status_next       = tlbt_pkg::ST_OK;
          found_first_next  = tlbt_pkg::FIELD_W'(rd_first);
          found_second_next = tlbt_pkg::FIELD_W'(rd_second);
          found_third_next  = tlbt_pkg::FIELD_W'(rd_third);
        end
      end
      default: begin
        status_next = tlbt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  assign count_next = count + CNT_W'(wr_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      status       <= status_next;
      found_tag    <= found_tag_next;
      found_first  <= found_first_next;
      found_second <= found_second_next;
      found_third  <= found_third_next;
      entry_count  <= tlbt_pkg::COUNT_W'(count_next);
    end
  end

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result beat missing two cycles after command");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count above table capacity");

  a_write_legal: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !match.full && !match.triple_hit && !match.tag_hit)
    else $error("insert written on clash or full table");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !wr_en |=> $stable(count))
    else $error("entry count moved without an insert");

endmodule
